FILE: rtl/core/rvsc_pkg.sv
// shared types, opcodes and constants for the rv32i subset core
`default_nettype none

package rvsc_pkg;

   // opcodes
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_HALT   = 7'h7F;
   localparam logic [6:0] OP_ZERO   = 7'h00;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3 codes
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0;
   localparam logic [2:0] F3_BNE = 3'd1;

   // request kinds carried in tuser
   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   // packed stream widths
   localparam int REQ_TDATA_BITS = 56;
   localparam int RSP_TDATA_BITS = 120;
   localparam int RSP_BITS       = 114;

   // response queue geometry
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_DEPTH    = 1 << RSP_PTR_BITS;

   // request payload, first field in the highest bits
   typedef struct packed {
      logic [7:0]  load_byte;
      logic [9:0]  load_addr;
      logic [31:0] instr;
   } req_data_type;

   // response payload, first field in the highest bits
   typedef struct packed {
      logic [31:0] mem_data;
      logic [9:0]  mem_addr;
      logic        mem_write;
      logic [31:0] reg_value;
      logic [4:0]  reg_index;
      logic        reg_write;
      logic        halted;
      logic [31:0] next_pc;
   } rsp_type;

   // register file write port
   typedef struct packed {
      logic        we;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_wr_type;

   // data memory access, address before wrap
   typedef struct packed {
      logic        we_word;
      logic        we_byte;
      logic [31:0] addr;
      logic [31:0] wdata;
   } dmem_req_type;

   // decoded and executed instruction
   typedef struct packed {
      logic [31:0] next_pc;
      logic        halt;
      logic        reg_we;
      logic [4:0]  rd;
      logic [31:0] alu_val;
      logic        is_load;
      logic        store;
      logic [31:0] mem_addr;
      logic [31:0] store_word;
   } exec_out_type;

endpackage

`default_nettype wire

FILE: rtl/core/rvsc_regfile.sv
// 32 x 32 register file memory with two registered read ports and reset valid bits
`default_nettype none

module rvsc_regfile
   import rvsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [4:0]  rd_idx_a,
   input  wire logic [4:0]  rd_idx_b,
   output      logic [31:0] rd_data_a,
   output      logic [31:0] rd_data_b,
   input  wire rf_wr_type   wr
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        rd_a_valid_ff;
   logic        rd_b_valid_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.idx] <= wr.data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_idx_a];
      rd_b_ff <= mem[rd_idx_b];
   end

   // valid bits, an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_a_valid_ff <= 1'b0;
         rd_b_valid_ff <= 1'b0;
      end else begin
         if (wr.we) begin
            valid_ff[wr.idx] <= 1'b1;
         end
         rd_a_valid_ff <= valid_ff[rd_idx_a];
         rd_b_valid_ff <= valid_ff[rd_idx_b];
      end
   end

   assign rd_data_a = rd_a_valid_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_b_valid_ff ? rd_b_ff : '0;

   // x0 is never written, so it always reads zero
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (wr.idx != 5'd0))
      else $error("register file write to x0");

   a_x0_invalid: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] == 1'b0)
      else $error("x0 marked as written");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      wr.we |=> valid_ff[$past(wr.idx)])
      else $error("written register not marked valid");

endmodule

`default_nettype wire

FILE: rtl/core/rvsc_dmem.sv
// byte data memory in four banks, one word or one byte a cycle, big-endian words
`default_nettype none

module rvsc_dmem
   import rvsc_pkg::*;
#(
   parameter int DMEM_BYTES = 1024
)
(
   input  wire logic         clock,
   input  wire dmem_req_type req,
   output      logic [31:0]  rd_word
);

   // size is a power of two, so the wrap is a mask
   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int ROWS = DMEM_BYTES / 4;
   localparam int RAW  = AW - 2;

   logic [1:0] base_lo_ff;
   logic [7:0] bank_rd [4];

   // low address bits select the byte rotation of the read word
   always_ff @(posedge clock) begin
      base_lo_ff <= req.addr[1:0];
   end

   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]     bank_mem [ROWS];
      logic [7:0]     rd_ff;
      logic [1:0]     offs;
      logic [31:0]    byte_addr;
      logic [AW-1:0]  wrap_addr;
      logic [RAW-1:0] row;
      logic [7:0]     wr_byte;
      logic           we;

      // byte k of the word lands in the bank of address base + k
      assign offs      = 2'(j) - req.addr[1:0];
      assign byte_addr = req.addr + {30'd0, offs};
      assign wrap_addr = byte_addr[AW-1:0];
      assign row       = wrap_addr[AW-1:2];
      assign wr_byte   = req.we_byte ? req.wdata[7:0]
                                     : 8'(req.wdata >> (5'd24 - {offs, 3'b000}));
      assign we        = req.we_word | (req.we_byte & (req.addr[1:0] == 2'(j)));

      always_ff @(posedge clock) begin
         if (we) begin
            bank_mem[row] <= wr_byte;
         end
         rd_ff <= bank_mem[row];
      end

      assign bank_rd[j] = rd_ff;
   end

   // most significant byte sits at the lowest address
   always_comb begin
      unique case (base_lo_ff)
         2'd0: rd_word = {bank_rd[0], bank_rd[1], bank_rd[2], bank_rd[3]};
         2'd1: rd_word = {bank_rd[1], bank_rd[2], bank_rd[3], bank_rd[0]};
         2'd2: rd_word = {bank_rd[2], bank_rd[3], bank_rd[0], bank_rd[1]};
         2'd3: rd_word = {bank_rd[3], bank_rd[0], bank_rd[1], bank_rd[2]};
         default: rd_word = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/rvsc_execute.sv
// instruction decode, alu, branch and address generation
`default_nettype none

module rvsc_execute
   import rvsc_pkg::*;
(
   input  wire logic [31:0] pc,
   input  wire logic        halted,
   input  wire logic        cmd,
   input  wire logic [31:0] instr,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output      exec_out_type ex
);

   logic [6:0]  op;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic        wr;

   // instruction fields and sign-extended immediates
   assign op    = instr[6:0];
   assign rd    = instr[11:7];
   assign f3    = instr[14:12];
   assign f7    = instr[31:25];
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

   // decode and execute
   always_comb begin
      ex            = '0;
      ex.next_pc    = pc;
      ex.rd         = rd;
      ex.store_word = op_b;
      ex.mem_addr   = op_a + imm_i;
      wr            = 1'b0;
      if (cmd == CMD_EXEC && !halted) begin
         ex.next_pc = pc + 32'd4;
         unique case (op)
            OP_HALT, OP_ZERO: begin
               ex.halt    = 1'b1;
               ex.next_pc = pc;
            end
            OP_LOAD: begin
               ex.is_load = 1'b1;
               wr         = 1'b1;
            end
            OP_STORE: begin
               ex.store    = 1'b1;
               ex.mem_addr = op_a + imm_s;
            end
            OP_BRANCH: begin
               if ((f3 == F3_BEQ && op_a == op_b) || (f3 == F3_BNE && op_a != op_b)) begin
                  ex.next_pc = pc + imm_b;
               end
            end
            OP_REG: begin
               if (f7 == F7_BASE) begin
                  wr = 1'b1;
                  unique case (f3)
                     F3_ADD:  ex.alu_val = op_a + op_b;
                     F3_XOR:  ex.alu_val = op_a ^ op_b;
                     F3_OR:   ex.alu_val = op_a | op_b;
                     F3_AND:  ex.alu_val = op_a & op_b;
                     default: wr = 1'b0;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                  wr         = 1'b1;
                  ex.alu_val = op_a - op_b;
               end
            end
            OP_IMM: begin
               wr = 1'b1;
               unique case (f3)
                  F3_ADD:  ex.alu_val = op_a + imm_i;
                  F3_XOR:  ex.alu_val = op_a ^ imm_i;
                  F3_OR:   ex.alu_val = op_a | imm_i;
                  F3_AND:  ex.alu_val = op_a & imm_i;
                  default: wr = 1'b0;
               endcase
            end
            OP_JAL: begin
               wr         = 1'b1;
               ex.alu_val = pc + 32'd4;
               ex.next_pc = pc + imm_j;
            end
            default: begin
            end
         endcase
      end
      ex.reg_we = wr && (rd != 5'd0);
   end

endmodule

`default_nettype wire

FILE: rtl/core/rvsc_rsp_fifo.sv
// small response queue that parts the pipeline from the result channel
`default_nettype none

module rvsc_rsp_fifo
   import rvsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rsp_type               push_data,
   input  wire logic                  pop,
   output      rsp_type               head,
   output      logic                  not_empty,
   output      logic [RSP_PTR_BITS:0] count
);

   rsp_type                 entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff;
   logic [RSP_PTR_BITS:0]   count_ff;
   logic [RSP_PTR_BITS:0]   count_in;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rv32i_subset_single_cycle_core.sv
// rv32i subset core: execute stage, write-back stage, then the response queue
// throughput one instruction per cycle with queue room; the loop that sets it is the
// register file read, forwarding and execute path, closed through the pc register
// reset clears pc, halt flag, pipeline and queue control and the register valid bits
// data memory is not cleared: its contents are undefined until preloaded or stored
// dmem_bytes must be a power of two
`default_nettype none

module rv32i_subset_single_cycle_core
   import rvsc_pkg::*;
#(
   parameter int DMEM_BYTES = 1024
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // instr[31:0], load_addr[41:32], load_byte[49:42], zero fill
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   // cmd[0]
   input  wire logic                      req_tuser,
   // response channel
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // next_pc[31:0], halted[32], reg_write[33], reg_index[38:34], reg_value[70:39],
   // mem_write[71], mem_addr[81:72], mem_data[113:82], zero fill
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam logic [31:0] DMEM_MASK = 32'(DMEM_BYTES - 1);

   req_data_type          req_data;
   logic                  req_accept;
   logic                  rsp_pop;
   logic [RSP_PTR_BITS:0] fifo_count;
   logic [RSP_PTR_BITS:0] inflight;
   rsp_type               fifo_head;
   logic                  fifo_not_empty;

   // architectural state
   logic [31:0] pc_ff;
   logic [31:0] pc_in;
   logic        halt_ff;
   logic        halt_in;

   // execute stage
   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   logic [31:0] s1_instr_ff;
   logic [9:0]  s1_load_addr_ff;
   logic [7:0]  s1_load_byte_ff;
   logic [31:0] rf_a;
   logic [31:0] rf_b;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [31:0] store_wrap;
   exec_out_type ex;
   dmem_req_type dmem_req;
   logic [31:0] dmem_word;

   // write-back stage
   logic        s2_valid_ff;
   logic [31:0] s2_next_pc_ff;
   logic        s2_halted_ff;
   logic        s2_reg_we_ff;
   logic [4:0]  s2_rd_ff;
   logic [31:0] s2_alu_val_ff;
   logic        s2_is_load_ff;
   logic        s2_mem_write_ff;
   logic [9:0]  s2_mem_addr_ff;
   logic [31:0] s2_mem_data_ff;
   logic [31:0] s2_value;
   rf_wr_type   rf_wr;
   rf_wr_type   last_wr_ff;
   rsp_type     s2_rsp;

   // request handshake: accept only with queue room for every item in flight
   assign req_data   = req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
   assign inflight   = fifo_count + {{RSP_PTR_BITS{1'b0}}, s1_valid_ff}
                                  + {{RSP_PTR_BITS{1'b0}}, s2_valid_ff};
   assign req_tready = (inflight < (RSP_PTR_BITS+1)'(RSP_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // register file, read at transfer time
   rvsc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_idx_a  (req_data.instr[19:15]),
      .rd_idx_b  (req_data.instr[24:20]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr        (rf_wr)
   );

   // execute stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff       <= req_tuser;
      s1_instr_ff     <= req_data.instr;
      s1_load_addr_ff <= req_data.load_addr;
      s1_load_byte_ff <= req_data.load_byte;
   end

   // operand forwarding from write-back and from the write of the last edge
   assign rs1      = s1_instr_ff[19:15];
   assign rs2      = s1_instr_ff[24:20];
   assign s2_value = s2_is_load_ff ? dmem_word : s2_alu_val_ff;

   always_comb begin
      priority if (s2_valid_ff && s2_reg_we_ff && s2_rd_ff == rs1) begin
         op_a = s2_value;
      end else if (last_wr_ff.we && last_wr_ff.idx == rs1) begin
         op_a = last_wr_ff.data;
      end else begin
         op_a = rf_a;
      end
      priority if (s2_valid_ff && s2_reg_we_ff && s2_rd_ff == rs2) begin
         op_b = s2_value;
      end else if (last_wr_ff.we && last_wr_ff.idx == rs2) begin
         op_b = last_wr_ff.data;
      end else begin
         op_b = rf_b;
      end
   end

   rvsc_execute u_execute (
      .pc     (pc_ff),
      .halted (halt_ff),
      .cmd    (s1_cmd_ff),
      .instr  (s1_instr_ff),
      .op_a   (op_a),
      .op_b   (op_b),
      .ex     (ex)
   );

   // pc and halt flag advance with each executed item
   assign pc_in   = s1_valid_ff ? ex.next_pc : pc_ff;
   assign halt_in = halt_ff | (s1_valid_ff & ex.halt);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   // data memory access: store or preload write, load read
   always_comb begin
      dmem_req.we_word = s1_valid_ff && ex.store;
      dmem_req.we_byte = s1_valid_ff && (s1_cmd_ff == CMD_PRELOAD);
      if (s1_cmd_ff == CMD_PRELOAD) begin
         dmem_req.addr  = 32'(s1_load_addr_ff);
         dmem_req.wdata = 32'(s1_load_byte_ff);
      end else begin
         dmem_req.addr  = ex.mem_addr;
         dmem_req.wdata = ex.store_word;
      end
   end

   rvsc_dmem #(
      .DMEM_BYTES (DMEM_BYTES)
   ) u_dmem (
      .clock   (clock),
      .req     (dmem_req),
      .rd_word (dmem_word)
   );

   // write-back stage registers
   assign store_wrap = ex.mem_addr & DMEM_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_next_pc_ff   <= ex.next_pc;
      s2_halted_ff    <= halt_in;
      s2_reg_we_ff    <= ex.reg_we;
      s2_rd_ff        <= ex.rd;
      s2_alu_val_ff   <= ex.alu_val;
      s2_is_load_ff   <= ex.is_load;
      s2_mem_write_ff <= ex.store;
      s2_mem_addr_ff  <= ex.store ? store_wrap[9:0] : '0;
      s2_mem_data_ff  <= ex.store ? ex.store_word : '0;
   end

   // register write and its copy for next-cycle forwarding
   assign rf_wr.we   = s2_valid_ff && s2_reg_we_ff;
   assign rf_wr.idx  = s2_rd_ff;
   assign rf_wr.data = s2_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_ff.we <= 1'b0;
      end else begin
         last_wr_ff.we <= rf_wr.we;
      end
      last_wr_ff.idx  <= rf_wr.idx;
      last_wr_ff.data <= rf_wr.data;
   end

   // response assembly, unused fields zero
   always_comb begin
      s2_rsp.next_pc   = s2_next_pc_ff;
      s2_rsp.halted    = s2_halted_ff;
      s2_rsp.reg_write = s2_reg_we_ff;
      s2_rsp.reg_index = s2_reg_we_ff ? s2_rd_ff : '0;
      s2_rsp.reg_value = s2_reg_we_ff ? s2_value : '0;
      s2_rsp.mem_write = s2_mem_write_ff;
      s2_rsp.mem_addr  = s2_mem_addr_ff;
      s2_rsp.mem_data  = s2_mem_data_ff;
   end

   // response queue and output transfer
   assign rsp_pop = rsp_tvalid && rsp_tready;

   rvsc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (s2_rsp),
      .pop       (rsp_pop),
      .head      (fifo_head),
      .not_empty (fifo_not_empty),
      .count     (fifo_count)
   );

   assign rsp_tvalid = fifo_not_empty;
   assign rsp_tdata  = {(RSP_TDATA_BITS-RSP_BITS)'(0), fifo_head};

   // queue never overflows under the in-flight credit
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_count < (RSP_PTR_BITS+1)'(RSP_DEPTH) || rsp_pop))
      else $error("response queue overflow");

   // a halted core holds its pc
   a_halt_holds_pc: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && halt_ff) |=> $stable(pc_ff))
      else $error("pc moved while halted");

   // a store and a preload never share a cycle
   a_one_dmem_write: assert property (@(posedge clock) disable iff (reset)
      !(dmem_req.we_word && dmem_req.we_byte))
      else $error("store and preload in one cycle");

   // halt flag only rises
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared");

endmodule

`default_nettype wire

FILE: test/rv32i_subset_single_cycle_core_test.sv
// testbench for the rv32i subset core: directed opening rows, random programs, then closing rows, checked in order
`timescale 1ns / 100ps

module rv32i_subset_single_cycle_core_test
   import rvsc_pkg::*;
();

   localparam int DMEM_BYTES   = 1024;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 27;
   localparam int REPORT_MAX   = 10;

   // encodings that the package leaves out
   localparam logic [2:0] F3_WORD   = 3'd2;
   localparam logic [2:0] F3_SHIFT  = 3'd1;
   localparam logic [6:0] F7_ODD    = 7'h01;
   localparam logic [6:0] OP_CUSTOM = 7'h0B;

   localparam logic [2:0] ALU_F3 [4] = '{F3_ADD, F3_XOR, F3_OR, F3_AND};

   // one stimulus row, with an optional typed-in result
   typedef struct {
      logic        cmd;
      logic [31:0] ins;
      logic [9:0]  la;
      logic [7:0]  lb;
      bit          known;
      rsp_type     typed;
   } stim_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // architectural copy of the core
   bit [31:0] core_pc;
   bit [31:0] gpr [32];
   bit [7:0]  dmem [DMEM_BYTES];
   bit        dmem_loaded [DMEM_BYTES];
   bit        core_halted;

   rsp_type      outcome_q [$];
   stim_row_type stim_table [$];
   rsp_type      seen, wanted;
   int unsigned  mismatches  = 0;
   int unsigned  rsp_count   = 0;
   int unsigned  cycle_count = 0;
   bit           quiet       = 1'b0;
   bit           hold_rsp    = 1'b0;

   rv32i_subset_single_cycle_core #(.DMEM_BYTES(DMEM_BYTES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // instruction encoders
   function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] s_word(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1);
      return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] b_word(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] j_word(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   function automatic rsp_type result_of(input logic [31:0] pc, input logic halted,
                                         input logic rw, input logic [4:0] idx,
                                         input logic [31:0] val, input logic mw,
                                         input logic [9:0] maddr, input logic [31:0] mdata);
      rsp_type r;
      r.next_pc   = pc;
      r.halted    = halted;
      r.reg_write = rw;
      r.reg_index = idx;
      r.reg_value = val;
      r.mem_write = mw;
      r.mem_addr  = maddr;
      r.mem_data  = mdata;
      return r;
   endfunction

   function automatic void add_row(input logic cmd, input logic [31:0] ins,
                                   input logic [9:0] la, input logic [7:0] lb,
                                   input bit known = 1'b0, input rsp_type typed = '0);
      stim_row_type row;
      row.cmd   = cmd;
      row.ins   = ins;
      row.la    = la;
      row.lb    = lb;
      row.known = known;
      row.typed = typed;
      stim_table.push_back(row);
   endfunction

   // retire one transfer on the architectural copy and return what the core reports
   function automatic rsp_type retire_instruction(input logic cmd, input logic [31:0] ins,
                                                  input logic [9:0] la, input logic [7:0] lb);
      rsp_type     r;
      logic [31:0] a, b, immi, imms, immb, immj, val;
      logic [9:0]  addr;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic        wr;
      r = '0;
      r.next_pc = core_pc;
      if (cmd == CMD_PRELOAD) begin
         dmem[la] = lb;
         dmem_loaded[la] = 1'b1;
      end else if (!core_halted) begin
         rd   = ins[11:7];
         f3   = ins[14:12];
         f7   = ins[31:25];
         a    = gpr[ins[19:15]];
         b    = gpr[ins[24:20]];
         immi = {{20{ins[31]}}, ins[31:20]};
         imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
         immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
         immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
         wr   = 1'b0;
         val  = '0;
         r.next_pc = core_pc + 32'd4;
         case (ins[6:0])
            OP_HALT, OP_ZERO: begin
               core_halted = 1'b1;
               r.next_pc = core_pc;
            end
            OP_LOAD: begin
               addr = a[9:0] + immi[9:0];
               val = {dmem[addr], dmem[addr + 10'd1], dmem[addr + 10'd2], dmem[addr + 10'd3]};
               wr = 1'b1;
            end
            OP_STORE: begin
               addr = a[9:0] + imms[9:0];
               dmem[addr]         = b[31:24];
               dmem[addr + 10'd1] = b[23:16];
               dmem[addr + 10'd2] = b[15:8];
               dmem[addr + 10'd3] = b[7:0];
               dmem_loaded[addr]         = 1'b1;
               dmem_loaded[addr + 10'd1] = 1'b1;
               dmem_loaded[addr + 10'd2] = 1'b1;
               dmem_loaded[addr + 10'd3] = 1'b1;
               r.mem_write = 1'b1;
               r.mem_addr  = addr;
               r.mem_data  = b;
            end
            OP_BRANCH: begin
               if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b))
                  r.next_pc = core_pc + immb;
            end
            OP_REG: begin
               if (f7 == F7_BASE) begin
                  wr = 1'b1;
                  case (f3)
                     F3_ADD: val = a + b;
                     F3_XOR: val = a ^ b;
                     F3_OR:  val = a | b;
                     F3_AND: val = a & b;
                     default: wr = 1'b0;
                  endcase
               end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                  val = a - b;
                  wr = 1'b1;
               end
            end
            OP_IMM: begin
               wr = 1'b1;
               case (f3)
                  F3_ADD: val = a + immi;
                  F3_XOR: val = a ^ immi;
                  F3_OR:  val = a | immi;
                  F3_AND: val = a & immi;
                  default: wr = 1'b0;
               endcase
            end
            OP_JAL: begin
               val = core_pc + 32'd4;
               wr = 1'b1;
               r.next_pc = core_pc + immj;
            end
            default: ;
         endcase
         // x0 stays zero
         if (wr && rd != 5'd0) begin
            gpr[rd]     = val;
            r.reg_write = 1'b1;
            r.reg_index = rd;
            r.reg_value = val;
         end
         core_pc = r.next_pc;
      end
      r.halted = core_halted;
      return r;
   endfunction

   // present one request, wait for its transfer, record the predicted result
   task automatic offer(input stim_row_type item);
      req_data_type payload;
      rsp_type      outcome;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      payload.instr     = item.ins;
      payload.load_addr = item.la;
      payload.load_byte = item.lb;
      req_tvalid <= 1'b1;
      req_tuser  <= item.cmd;
      req_tdata  <= REQ_TDATA_BITS'(payload);
      do @(posedge clock); while (!req_tready);
      outcome = retire_instruction(item.cmd, item.ins, item.la, item.lb);
      outcome_q.push_back(item.known ? item.typed : outcome);
      @(negedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      stim_row_type item;
      int           opening, n, i, tries, pick;
      bit           found;
      logic [9:0]   base, offs;
      logic [4:0]   rs1, rs2, rd;
      logic [2:0]   f3;
      logic [6:0]   f7, op, halt_op, other_halt;

      // opening rows: reset values, extremes, wraps, every operation but halt
      add_row(CMD_EXEC, i_word(12'hFFF, 5'd0, F3_ADD, 5'd1, OP_IMM), '0, '0, 1'b1,
              result_of(32'd4, 1'b0, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0, '0, '0));
      add_row(CMD_EXEC, r_word(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd2), '0, '0, 1'b1,
              result_of(32'd8, 1'b0, 1'b1, 5'd2, 32'hFFFF_FFFE, 1'b0, '0, '0));
      add_row(CMD_EXEC, i_word(12'd5, 5'd1, F3_ADD, 5'd0, OP_IMM), '0, '0, 1'b1,
              result_of(32'd12, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0));
      add_row(CMD_PRELOAD, 32'hFFFF_FFFF, 10'd0, 8'h12, 1'b1,
              result_of(32'd12, 1'b0, 1'b0, '0, '0, 1'b0, '0, '0));
      add_row(CMD_PRELOAD, '0, 10'd1, 8'h34);
      add_row(CMD_PRELOAD, '0, 10'd2, 8'h56);
      add_row(CMD_PRELOAD, '0, 10'd3, 8'h78);
      add_row(CMD_PRELOAD, '0, 10'd1023, 8'hFF);
      add_row(CMD_PRELOAD, '0, 10'd1022, 8'hA5);
      add_row(CMD_EXEC, i_word(12'd0, 5'd0, F3_WORD, 5'd3, OP_LOAD), '0, '0, 1'b1,
              result_of(32'd16, 1'b0, 1'b1, 5'd3, 32'h1234_5678, 1'b0, '0, '0));
      // word load that wraps below address zero
      add_row(CMD_EXEC, i_word(12'hFFE, 5'd0, F3_WORD, 5'd4, OP_LOAD), '0, '0);
      // store with a negative offset, wrapping at the top of memory
      add_row(CMD_EXEC, s_word(12'hFFF, 5'd1, 5'd0), '0, '0, 1'b1,
              result_of(32'd24, 1'b0, 1'b0, '0, '0, 1'b1, 10'd1023, 32'hFFFF_FFFF));
      add_row(CMD_EXEC, i_word(12'h7FF, 5'd0, F3_WORD, 5'd5, OP_LOAD), '0, '0);
      add_row(CMD_EXEC, r_word(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd6), '0, '0);
      add_row(CMD_EXEC, r_word(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd7), '0, '0);
      add_row(CMD_EXEC, r_word(F7_BASE, 5'd4, 5'd3, F3_OR, 5'd8), '0, '0);
      add_row(CMD_EXEC, r_word(F7_BASE, 5'd4, 5'd3, F3_AND, 5'd9), '0, '0);
      add_row(CMD_EXEC, i_word(12'hFFF, 5'd3, F3_XOR, 5'd10, OP_IMM), '0, '0);
      add_row(CMD_EXEC, i_word(12'h7FF, 5'd0, F3_OR, 5'd11, OP_IMM), '0, '0);
      add_row(CMD_EXEC, i_word(12'h800, 5'd1, F3_AND, 5'd12, OP_IMM), '0, '0);
      add_row(CMD_EXEC, b_word(13'h1000, 5'd5, 5'd1, F3_BEQ), '0, '0);
      add_row(CMD_EXEC, b_word(13'h0FFE, 5'd2, 5'd1, F3_BNE), '0, '0);
      // branch with an unused funct3 is never taken
      add_row(CMD_EXEC, b_word(13'h0040, 5'd0, 5'd0, F3_WORD), '0, '0);
      add_row(CMD_EXEC, j_word(21'h10_0000, 5'd31), '0, '0);
      add_row(CMD_EXEC, j_word(21'h0F_FFFE, 5'd0), '0, '0);
      // unknown opcode and unknown function codes only step the pc
      add_row(CMD_EXEC, i_word(12'hABC, 5'd3, F3_XOR, 5'd7, OP_CUSTOM), '0, '0);
      add_row(CMD_EXEC, r_word(F7_ODD, 5'd2, 5'd1, F3_ADD, 5'd13), '0, '0);
      add_row(CMD_EXEC, r_word(F7_ALT, 5'd2, 5'd1, F3_XOR, 5'd13), '0, '0);
      add_row(CMD_EXEC, i_word(12'h123, 5'd1, F3_SHIFT, 5'd14, OP_IMM), '0, '0);
      opening = stim_table.size();

      // closing rows: halt, then execute and preload while halted
      halt_op    = $urandom_range(0, 1) ? OP_HALT : OP_ZERO;
      other_halt = (halt_op == OP_HALT) ? OP_ZERO : OP_HALT;
      add_row(CMD_EXEC, {25'($urandom), halt_op}, '0, '0);
      add_row(CMD_EXEC, r_word(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd1), '0, '0);
      add_row(CMD_PRELOAD, 32'h0, 10'h155, 8'hAA);
      add_row(CMD_EXEC, {25'($urandom), other_halt}, '0, '0);

      // reset
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < opening; i++)
         offer(stim_table[i]);

      // random programs
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 600 && n < 750);
         if (n == 200)
            hold_rsp = 1'b1;
         if (n == 450) begin
            // let every outstanding result come back first
            req_tvalid <= 1'b0;
            do @(negedge clock); while (outcome_q.size() != 0);
         end
         item.cmd   = CMD_EXEC;
         item.ins   = $urandom;
         item.la    = 10'($urandom);
         item.lb    = 8'($urandom);
         item.known = 1'b0;
         item.typed = '0;
         rs1 = 5'($urandom);
         rs2 = 5'($urandom);
         rd  = 5'($urandom);
         f3  = ALU_F3[$urandom_range(0, 3)];
         if ($urandom_range(0, 4) == 0)
            f3 = 3'($urandom);
         f7 = ($urandom_range(0, 9) < 3) ? F7_ALT : F7_BASE;
         if ($urandom_range(0, 19) == 0)
            f7 = 7'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            item.cmd = CMD_PRELOAD;
         end else if (pick < 27) begin
            // word load aimed at four bytes already written
            found = 1'b0;
            for (tries = 0; tries < 16 && !found; tries++) begin
               base  = 10'($urandom);
               found = dmem_loaded[base] && dmem_loaded[base + 10'd1] &&
                       dmem_loaded[base + 10'd2] && dmem_loaded[base + 10'd3];
            end
            if (found) begin
               offs = base - gpr[rs1][9:0];
               item.ins = i_word({2'($urandom), offs}, rs1, F3_WORD, rd, OP_LOAD);
            end else
               item.cmd = CMD_PRELOAD;
         end else if (pick < 39) begin
            item.ins = s_word(12'($urandom), rs2, rs1);
         end else if (pick < 51) begin
            pick = $urandom_range(0, 9);
            f3 = (pick < 4) ? F3_BEQ : (pick < 8) ? F3_BNE :
                 3'($urandom_range(F3_BNE + 1, F3_AND));
            if ($urandom_range(0, 3) == 0)
               rs2 = rs1;
            item.ins = b_word(13'($urandom), rs2, rs1, f3);
         end else if (pick < 66) begin
            item.ins = r_word(f7, rs2, rs1, f3, rd);
         end else if (pick < 81) begin
            item.ins = i_word(12'($urandom), rs1, f3, rd, OP_IMM);
         end else if (pick < 87) begin
            item.ins = j_word(21'($urandom), rd);
         end else if (pick < 93) begin
            do op = 7'($urandom);
            while (op == OP_LOAD || op == OP_STORE || op == OP_BRANCH || op == OP_REG ||
                   op == OP_IMM || op == OP_JAL || op == OP_HALT || op == OP_ZERO);
            item.ins = {item.ins[31:7], op};
         end else begin
            // raw word, never a halt and never a blind load
            while (item.ins[6:0] == OP_LOAD || item.ins[6:0] == OP_HALT ||
                   item.ins[6:0] == OP_ZERO)
               item.ins = $urandom;
         end
         offer(item);
      end
      quiet = 1'b0;

      for (i = opening; i < stim_table.size(); i++)
         offer(stim_table[i]);
      req_tvalid <= 1'b0;

      // wait for the last results, then let the core idle before the verdict
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // result side ready, with one long hold-off
   initial begin : rsp_side
      int held;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++)
               @(negedge clock);
            hold_done = 1'b1;
         end else
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result %0d arrived with nothing outstanding, next_pc %h",
                        rsp_count, seen.next_pc);
         end else begin
            wanted = outcome_q.pop_front();
            if (seen !== wanted) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("result %0d differs", rsp_count);
                  $display("  expected pc %h halt %b rw %b rd %0d val %h mw %b addr %0d data %h",
                           wanted.next_pc, wanted.halted, wanted.reg_write, wanted.reg_index,
                           wanted.reg_value, wanted.mem_write, wanted.mem_addr,
                           wanted.mem_data);
                  $display("  actual   pc %h halt %b rw %b rd %0d val %h mw %b addr %0d data %h",
                           seen.next_pc, seen.halted, seen.reg_write, seen.reg_index,
                           seen.reg_value, seen.mem_write, seen.mem_addr, seen.mem_data);
               end
            end
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
